[src/ittw_pkg.sv]
// shared types and constants for the integer to word token converter
package ittw_pkg;

	localparam int VALUE_W   = 31;
	localparam int WORD_W    = 5;
	localparam int NUM_DIGITS = 10;
	localparam int CNT_W     = $clog2(VALUE_W);

	// token codes
	localparam logic [WORD_W-1:0] TOK_ZERO     = 5'd0;
	localparam logic [WORD_W-1:0] TOK_TEN      = 5'd10;
	localparam logic [WORD_W-1:0] TOK_TENS0    = 5'd18;
	localparam logic [WORD_W-1:0] TOK_HUNDRED  = 5'd28;
	localparam logic [WORD_W-1:0] TOK_THOUSAND = 5'd29;
	localparam logic [WORD_W-1:0] TOK_MILLION  = 5'd30;
	localparam logic [WORD_W-1:0] TOK_BILLION  = 5'd31;

	// group index, billions first
	localparam logic [1:0] GRP_BILLION  = 2'd0;
	localparam logic [1:0] GRP_MILLION  = 2'd1;
	localparam logic [1:0] GRP_THOUSAND = 2'd2;
	localparam logic [1:0] GRP_UNITS    = 2'd3;

	// steps within one group
	localparam logic [2:0] STP_HDIGIT  = 3'd0;
	localparam logic [2:0] STP_HUNDRED = 3'd1;
	localparam logic [2:0] STP_TENS    = 3'd2;
	localparam logic [2:0] STP_ONES    = 3'd3;
	localparam logic [2:0] STP_SCALE   = 3'd4;

	typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

	// conversion result handed from the bcd converter to the token sequencer
	typedef struct packed {
		logic    done;
		digits_t dig;
	} bcd_res_t;

endpackage

[src/integer_to_word_tokens.sv]
// top level of the integer to english word token converter
//
// Takes one unsigned 31-bit value per input transfer and returns its English
// spelling as a run of 5-bit word tokens, one token per output transfer, with
// m_tlast on the final token. Token codes: 0 Zero, 1..19 One..Nineteen,
// 20..27 Twenty..Ninety, 28 Hundred, 29 Thousand, 30 Million, 31 Billion.
// A value of zero gives the single token Zero. One value is handled at a
// time: the value first runs through a bit-serial binary to bcd converter,
// then a sequencer walks the billions, millions, thousands and units groups
// in five steps each (20 steps, one per cycle, a step that yields a token
// waits for the output register to free). The block takes the next value
// only after the sequencer has finished. The last token may still sit in
// the output register while the next value is already taken.
module integer_to_word_tokens (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [30:0] value, [31] zero fill
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [4:0] word, [7:5] zero fill
	output logic        m_tlast
);

	logic                          bcd_busy;
	logic                          emit_busy;
	logic                          start;
	ittw_pkg::bcd_res_t            bcd_res;
	logic [ittw_pkg::WORD_W-1:0]   word;

	// a new value is taken only when both the converter and the sequencer are free
	assign s_tready = !bcd_busy && !emit_busy;
	assign start    = s_tvalid && s_tready;

	// bit-serial decimal conversion
	ittw_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (s_tdata[ittw_pkg::VALUE_W-1:0]),
		.busy   (bcd_busy),
		.res    (bcd_res)
	);

	// group walk and output register
	ittw_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (bcd_res),
		.busy      (emit_busy),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (word),
		.out_last  (m_tlast)
	);

	assign m_tdata = {3'b000, word};

endmodule

[src/ittw_bcd.sv]
// serial binary to bcd converter, one input bit per cycle (shift and add three)
module ittw_bcd (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ittw_pkg::VALUE_W-1:0]  value,
	output logic                          busy,
	output ittw_pkg::bcd_res_t            res
);

	logic [ittw_pkg::VALUE_W-1:0] bin_q;
	ittw_pkg::digits_t            bcd_q;
	ittw_pkg::digits_t            adj;
	logic [ittw_pkg::NUM_DIGITS*4-1:0] adj_bits;
	logic [ittw_pkg::CNT_W-1:0]   cnt_q;
	logic                         run_q;
	logic                         done_q;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < ittw_pkg::NUM_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	// flat view of the adjusted digits for the one-bit shift
	assign adj_bits = adj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= ittw_pkg::CNT_W'(ittw_pkg::VALUE_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (run_q) begin
			bin_q <= {bin_q[ittw_pkg::VALUE_W-2:0], 1'b0};
			bcd_q <= {adj_bits[ittw_pkg::NUM_DIGITS*4-2:0], bin_q[ittw_pkg::VALUE_W-1]};
		end
	end

	assign busy     = run_q | done_q;
	assign res.done = done_q;
	assign res.dig  = bcd_q;

endmodule

[src/ittw_emit.sv]
// token sequencer: walks the four digit groups and drives the output register
module ittw_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ittw_pkg::bcd_res_t            res,
	output logic                          busy,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ittw_pkg::WORD_W-1:0]   out_word,
	output logic                          out_last
);

	ittw_pkg::digits_t          dig_q;
	logic                       run_q;
	logic                       zero_q;
	logic [1:0]                 grp_q;
	logic [2:0]                 stp_q;
	logic                       ovalid_q;
	logic [ittw_pkg::WORD_W-1:0] oword_q;
	logic                       olast_q;

	logic [3:0]                 h, t, o;
	logic [3:0]                 nz;
	logic                       later_nz;
	logic                       gnz;
	logic                       emit;
	logic                       fin_step;
	logic [ittw_pkg::WORD_W-1:0] tok;
	logic                       free;
	logic                       adv;
	logic                       finish;

	// nonzero flag of each group
	assign nz[0] = dig_q[9] != 4'd0;
	assign nz[1] = (dig_q[8] | dig_q[7] | dig_q[6]) != 4'd0;
	assign nz[2] = (dig_q[5] | dig_q[4] | dig_q[3]) != 4'd0;
	assign nz[3] = (dig_q[2] | dig_q[1] | dig_q[0]) != 4'd0;

	always_comb begin
		unique case (grp_q)
			ittw_pkg::GRP_BILLION: begin
				h = 4'd0;     t = 4'd0;     o = dig_q[9];
				later_nz = nz[1] | nz[2] | nz[3];
			end
			ittw_pkg::GRP_MILLION: begin
				h = dig_q[8]; t = dig_q[7]; o = dig_q[6];
				later_nz = nz[2] | nz[3];
			end
			ittw_pkg::GRP_THOUSAND: begin
				h = dig_q[5]; t = dig_q[4]; o = dig_q[3];
				later_nz = nz[3];
			end
			default: begin
				h = dig_q[2]; t = dig_q[1]; o = dig_q[0];
				later_nz = 1'b0;
			end
		endcase
	end

	assign gnz = (h | t | o) != 4'd0;

	// decide whether the current step gives a token, and whether it closes the group
	always_comb begin
		emit     = 1'b0;
		fin_step = 1'b0;
		tok      = ittw_pkg::TOK_ZERO;
		if (zero_q) begin
			emit     = 1'b1;
			fin_step = 1'b1;
		end else begin
			unique case (stp_q)
				ittw_pkg::STP_HDIGIT: begin
					emit = h != 4'd0;
					tok  = {1'b0, h};
				end
				ittw_pkg::STP_HUNDRED: begin
					emit     = h != 4'd0;
					tok      = ittw_pkg::TOK_HUNDRED;
					fin_step = (grp_q == ittw_pkg::GRP_UNITS) && (t == 4'd0) && (o == 4'd0);
				end
				ittw_pkg::STP_TENS: begin
					if (t >= 4'd2) begin
						emit = 1'b1;
						tok  = ittw_pkg::TOK_TENS0 + {1'b0, t};
					end else if (t == 4'd1) begin
						emit = 1'b1;
						tok  = ittw_pkg::TOK_TEN + {1'b0, o};
					end else begin
						emit = o != 4'd0;
						tok  = {1'b0, o};
					end
					fin_step = (grp_q == ittw_pkg::GRP_UNITS) && !((t >= 4'd2) && (o != 4'd0));
				end
				ittw_pkg::STP_ONES: begin
					emit     = (t >= 4'd2) && (o != 4'd0);
					tok      = {1'b0, o};
					fin_step = grp_q == ittw_pkg::GRP_UNITS;
				end
				ittw_pkg::STP_SCALE: begin
					emit     = gnz && (grp_q != ittw_pkg::GRP_UNITS);
					fin_step = 1'b1;
					case (grp_q)
						ittw_pkg::GRP_BILLION:  tok = ittw_pkg::TOK_BILLION;
						ittw_pkg::GRP_MILLION:  tok = ittw_pkg::TOK_MILLION;
						default:                tok = ittw_pkg::TOK_THOUSAND;
					endcase
				end
				default: begin
					emit = 1'b0;
				end
			endcase
			emit = emit && gnz;
		end
	end

	assign free   = !ovalid_q || out_ready;
	assign adv    = run_q && (!emit || free);
	assign finish = zero_q || ((grp_q == ittw_pkg::GRP_UNITS) && (stp_q == ittw_pkg::STP_SCALE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			zero_q   <= 1'b0;
			grp_q    <= ittw_pkg::GRP_BILLION;
			stp_q    <= ittw_pkg::STP_HDIGIT;
			ovalid_q <= 1'b0;
		end else begin
			if (res.done) begin
				run_q  <= 1'b1;
				zero_q <= res.dig == '0;
				grp_q  <= ittw_pkg::GRP_BILLION;
				stp_q  <= ittw_pkg::STP_HDIGIT;
			end else if (adv) begin
				if (finish) begin
					run_q  <= 1'b0;
					zero_q <= 1'b0;
				end else if (stp_q == ittw_pkg::STP_SCALE) begin
					stp_q <= ittw_pkg::STP_HDIGIT;
					grp_q <= grp_q + 2'd1;
				end else begin
					stp_q <= stp_q + 3'd1;
				end
			end
			if (adv && emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			dig_q <= res.dig;
		end
		if (adv && emit) begin
			oword_q <= tok;
			olast_q <= fin_step && !later_nz;
		end
	end

	assign busy      = run_q;
	assign out_valid = ovalid_q;
	assign out_word  = oword_q;
	assign out_last  = olast_q;

endmodule
